// File: rtl/lvd_pkg.sv
package lvd_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned GroupW    = 7;
  localparam int unsigned ValueW    = 64;
  localparam int unsigned WidthW    = 7;
  localparam int unsigned CountW    = 4;
  localparam int unsigned ShiftW    = 6;
  localparam int unsigned MaxBytes  = 10;
  localparam int unsigned OutDataW  = 72;

  localparam logic [WidthW-1:0] MinWidth = WidthW'(1);
  localparam logic [WidthW-1:0] MaxWidth = WidthW'(64);

  localparam logic StatusOk  = 1'b0;
  localparam logic StatusErr = 1'b1;

  typedef struct packed {
    logic [ByteW-1:0]  byte_in;
    logic              is_signed;
    logic [WidthW-1:0] width_bits;
  } in_beat_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              status;
    logic [CountW-1:0] byte_count;
  } result_t;

endpackage

// File: rtl/lvd_in_stage.sv
module lvd_in_stage
  import lvd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_valid_i,
  output logic     s_ready_o,
  input  in_beat_t s_beat_i,
  input  logic     take_i,
  output logic     valid_o,
  output in_beat_t beat_o
);

  logic     valid_q, valid_d;
  in_beat_t beat_q;

  assign s_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (s_valid_i && s_ready_o) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      beat_q <= s_beat_i;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

// File: rtl/lvd_decode.sv
module lvd_decode
  import lvd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fire_i,
  input  in_beat_t beat_i,
  output logic     res_valid_o,
  output result_t  res_o
);

  logic [ValueW-1:0] acc_q, acc_d;
  logic [WidthW-1:0] left_q, left_d;
  logic [ShiftW-1:0] shift_q, shift_d;
  logic              sm_q, sm_d;
  logic              in_num_q, in_num_d;
  logic [CountW-1:0] cnt_q, cnt_d;

  logic [ValueW-1:0] acc_c;
  logic [WidthW-1:0] left_c, width_c, lm1;
  logic [ShiftW-1:0] shift_c;
  logic              sm_c;
  logic [CountW-1:0] cnt_c;
  logic [GroupW-1:0] grp;
  logic [ByteW-1:0]  lim, half, thr;
  logic [ValueW-1:0] g64;
  logic              ok;

  always_comb begin
    width_c = beat_i.width_bits;
    if (width_c < MinWidth) begin
      width_c = MinWidth;
    end else if (width_c > MaxWidth) begin
      width_c = MaxWidth;
    end
    if (!in_num_q) begin
      acc_c   = '0;
      left_c  = width_c;
      shift_c = '0;
      sm_c    = beat_i.is_signed;
      cnt_c   = '0;
    end else begin
      acc_c   = acc_q;
      left_c  = left_q;
      shift_c = shift_q;
      sm_c    = sm_q;
      cnt_c   = cnt_q;
    end
    cnt_c = cnt_c + CountW'(1);
    grp   = beat_i.byte_in[GroupW-1:0];
    lm1   = left_c - WidthW'(1);
    lim   = ByteW'(1) << left_c[2:0];
    half  = ByteW'(1) << lm1[2:0];
    thr   = ByteW'(128) - half;

    if (!sm_c) begin
      ok  = (left_c >= WidthW'(GroupW)) || ({1'b0, grp} < lim);
      g64 = ValueW'(grp);
    end else if (!grp[GroupW-1]) begin
      ok  = (left_c >= WidthW'(GroupW)) || ({1'b0, grp} < half);
      g64 = ValueW'(grp);
    end else begin
      ok  = (left_c >= WidthW'(GroupW + 1)) || ({1'b0, grp} >= thr);
      g64 = {{(ValueW-GroupW){1'b1}}, grp};
    end

    acc_d    = acc_c;
    left_d   = left_c;
    shift_d  = shift_c;
    sm_d     = sm_c;
    cnt_d    = cnt_c;
    in_num_d = 1'b0;
    res_valid_o      = 1'b1;
    res_o.value      = '0;
    res_o.status     = StatusErr;
    res_o.byte_count = cnt_c;

    if (beat_i.byte_in[ByteW-1]) begin
      if (left_c > WidthW'(GroupW)) begin
        acc_d       = acc_c | (ValueW'(grp) << shift_c);
        left_d      = left_c - WidthW'(GroupW);
        shift_d     = shift_c + ShiftW'(GroupW);
        in_num_d    = 1'b1;
        res_valid_o = 1'b0;
      end
    end else if (ok) begin
      res_o.value  = acc_c | (g64 << shift_c);
      res_o.status = StatusOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      left_q   <= '0;
      shift_q  <= '0;
      sm_q     <= 1'b0;
      in_num_q <= 1'b0;
      cnt_q    <= '0;
    end else if (fire_i) begin
      acc_q    <= acc_d;
      left_q   <= left_d;
      shift_q  <= shift_d;
      sm_q     <= sm_d;
      in_num_q <= in_num_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// File: rtl/lvd_out_stage.sv
module lvd_out_stage
  import lvd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    ready_o,
  output logic    m_valid_o,
  input  logic    m_ready_i,
  output result_t m_res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign ready_o = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_valid_o = valid_q;
  assign m_res_o   = res_q;

endmodule

// File: rtl/leb128_varint_decoder_top.sv
// The final input beat of a number is registered in the input stage, then decoded into the output stage.
// Throughput: one input beat per cycle while the output is not stalled, set by the accumulator.
// A result beat that waits on m_axis_tready_i holds every input beat, also continuation beats.
// A byte that ends no number and raises no error gives no result beat.
// Reset (rst_ni low, asynchronous) empties both stages and awaits a first byte.
module leb128_varint_decoder_top
  import lvd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [ByteW-1:0]    s_axis_tdata_i,  // byte_in
  input  logic [ByteW-1:0]    s_axis_tuser_i,  // is_signed, width_bits
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,  // value, byte_count, zero fill
  output logic                m_axis_tuser_o   // status
);

  in_beat_t s_beat, beat;
  result_t  res, m_res;
  logic     in_valid, out_ready, fire, res_valid;

  assign s_beat.byte_in    = s_axis_tdata_i;
  assign s_beat.is_signed  = s_axis_tuser_i[0];
  assign s_beat.width_bits = s_axis_tuser_i[WidthW:1];

  assign fire = in_valid && out_ready;

  lvd_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_beat_i  (s_beat),
    .take_i    (fire),
    .valid_o   (in_valid),
    .beat_o    (beat)
  );

  lvd_decode u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .beat_i      (beat),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  lvd_out_stage u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (fire && res_valid),
    .res_i     (res),
    .ready_o   (out_ready),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_res_o   (m_res)
  );

  assign m_axis_tdata_o = {{(OutDataW-ValueW-CountW){1'b0}}, m_res.byte_count, m_res.value};
  assign m_axis_tuser_o = m_res.status;

endmodule

// File: rtl/lvd_checker.sv
module lvd_checker
  import lvd_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic [ByteW-1:0]    s_axis_tdata_i,
  input logic [ByteW-1:0]    s_axis_tuser_i,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o,
  input logic                m_axis_tuser_o
);

  logic [CountW-1:0] cnt;
  assign cnt = m_axis_tdata_o[ValueW +: CountW];

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result beat changed while stalled");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (cnt != '0) && (cnt <= CountW'(MaxBytes)))
    else $error("byte count out of range");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == StatusErr) |-> m_axis_tdata_o[ValueW-1:0] == '0)
    else $error("error beat carries a nonzero value");

endmodule

bind leb128_varint_decoder_top lvd_checker u_lvd_checker (.*);
